### src/alle_pkg.sv
// shared types and constants of the array linked list engine
// no dependencies: compiled first

package alle_pkg;

    // default sizes of the slot store
    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // fixed field widths of the request and response channels
    localparam int KIND_W    = 2;
    localparam int ELEM_IN_W = 32;
    localparam int POS_W     = 7;
    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_REMOVE = 2'd3
    } t_kind;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_POS    = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NOT_IN_USE = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_SEARCH,
        S_TAKE0,
        S_TAKE1,
        S_TAKE2,
        S_TAKE3,
        S_RM1,
        S_RM2,
        S_FINISH
    } t_state;

endpackage

### src/alle_if.sv
// request and response channel interfaces of the array linked list engine
// depends on alle_pkg

interface alle_req_if;
    import alle_pkg::*;

    logic                        valid;
    logic                        ready;
    t_kind                       kind;
    logic signed [ELEM_IN_W-1:0] element;
    logic        [POS_W-1:0]     position;
    logic        [SLOT_W-1:0]    slot;

    modport source (output valid, kind, element, position, slot, input ready);
    modport sink   (input valid, kind, element, position, slot, output ready);
endinterface

interface alle_rsp_if;
    import alle_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic               found;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] count;

    modport source (output valid, status, found, slot_index, count, input ready);
    modport sink   (input valid, status, found, slot_index, count, output ready);
endinterface

### src/alle_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/array_linked_list_engine.sv
// array linked list engine: doubly linked list over a slot store with a free list
// depends on alle_pkg, alle_if (alle_req_if, alle_rsp_if) and alle_ram
//
// Usage: requests arrive on i_req (kind, element, position, slot) and each one
// gives exactly one response on o_rsp (status, found, slot_index, count).
// One request is processed at a time; i_req.ready is high only while the
// sequencer is idle. The links live in rams with one read and one write port,
// so a list walk visits one link per clock.
// An insert at position p>0 follows links from the head to the insert point
// before it takes the free head slot; an insert at position 0 and an append
// take it at once. A search visits at most CAPACITY nodes. A rejected request
// finishes without changing the lists.
// The next request can transfer in the cycle its response turns valid.
// After reset a clearing pass builds the free list and clears the in-use bits;
// no request is taken during it.
// A finished response sits in an output register; when the receiver stalls,
// the next request is still taken and processed, and its response waits
// until the previous one has been transferred.

module array_linked_list_engine #(
    parameter int CAPACITY      = alle_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = alle_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    alle_req_if.sink       i_req,
    alle_rsp_if.source     o_rsp
);
    import alle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int XW = (LW > POS_W) ? LW : POS_W;
    localparam int EW = ELEMENT_WIDTH;
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
    localparam logic [XW-1:0] CAP_X     = XW'(CAPACITY);

    // sequencer and list registers
    t_state           r_state, n_state;
    logic [LW-1:0]    r_head, n_head;
    logic [LW-1:0]    r_tail, n_tail;
    logic [LW-1:0]    r_free, n_free;
    logic [LW-1:0]    r_count, n_count;
    logic [LW-1:0]    r_cur, n_cur;
    logic [LW-1:0]    r_nxt, n_nxt;
    logic [LW-1:0]    r_where, n_where;
    logic [XW-1:0]    r_steps, n_steps;
    t_status          r_status, n_status;
    logic             r_found, n_found;

    // latched request
    t_kind            r_kind;
    logic [EW-1:0]    r_elem;
    logic [POS_W-1:0] r_pos;
    logic [SLOT_W-1:0] r_slot;

    // response register
    logic               r_ov, n_ov;
    t_status            r_o_status;
    logic               r_o_found;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [COUNT_W-1:0] r_o_count;
    logic               w_load_out;

    // ram ports
    logic          nx_we, pv_we, iu_we, el_we;
    logic [AW-1:0] nx_wa, pv_wa, iu_wa, el_wa;
    logic [LW-1:0] nx_wd, pv_wd;
    logic          iu_wd;
    logic [AW-1:0] nx_ra, pv_ra, iu_ra, el_ra;
    logic [LW-1:0] nx_rd, pv_rd;
    logic          iu_rd;
    logic [EW-1:0] el_rd;

    // shared compare terms
    logic          w_accept;
    logic          w_cur_ok, w_head_ok, w_free_ok, w_nx_ok, w_pv_ok, w_nxt_ok;
    logic          w_slot_ok, w_pos_bad, w_walk_start, w_walk_more, w_search_more;
    logic          w_match;
    logic [XW-1:0] w_step1;
    logic [LW-1:0] w_slot_l;
    logic [LW-1:0] w_take_nxt;

    assign w_accept      = i_req.valid && i_req.ready;
    assign w_cur_ok      = r_cur < NULL_LINK;
    assign w_head_ok     = r_head < NULL_LINK;
    assign w_free_ok     = r_free < NULL_LINK;
    assign w_nx_ok       = nx_rd < NULL_LINK;
    assign w_pv_ok       = pv_rd < NULL_LINK;
    assign w_nxt_ok      = r_nxt < NULL_LINK;
    assign w_slot_ok     = XW'(r_slot) < CAP_X;
    assign w_slot_l      = LW'(r_slot);
    assign w_pos_bad     = XW'(r_pos) > XW'(r_count);
    assign w_step1       = r_steps + XW'(1);
    assign w_walk_start  = (XW'(1) < XW'(r_pos)) && (XW'(1) < CAP_X) && w_head_ok;
    assign w_walk_more   = (w_step1 < XW'(r_pos)) && (w_step1 < CAP_X) && w_nx_ok;
    assign w_search_more = (w_step1 < CAP_X) && w_nx_ok;
    assign w_match       = el_rd == r_elem;
    assign w_take_nxt    = w_cur_ok ? nx_rd : r_head;
    assign w_load_out    = (r_state == S_FINISH) && (!r_ov || o_rsp.ready);

    // link, prev, in-use and element stores
    alle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd)
    );
    alle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd)
    );
    alle_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used_ram (
        .i_clk(i_clk), .i_we(iu_we), .i_waddr(iu_wa), .i_wdata(iu_wd),
        .i_raddr(iu_ra), .o_rdata(iu_rd)
    );
    alle_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_elem_ram (
        .i_clk(i_clk), .i_we(el_we), .i_waddr(el_wa), .i_wdata(r_elem),
        .i_raddr(el_ra), .o_rdata(el_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cur == LW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_kind)
                    KIND_INSERT: begin
                        if (w_pos_bad || !w_free_ok) begin
                            n_state = S_FINISH;
                        end else if (w_walk_start) begin
                            n_state = S_WALK;
                        end else begin
                            n_state = S_TAKE0;
                        end
                    end
                    KIND_APPEND: begin
                        n_state = w_free_ok ? S_TAKE0 : S_FINISH;
                    end
                    KIND_SEARCH: begin
                        n_state = w_head_ok ? S_SEARCH : S_FINISH;
                    end
                    default: begin
                        n_state = w_slot_ok ? S_RM1 : S_FINISH;
                    end
                endcase
            end
            S_WALK: begin
                if (!w_walk_more) begin
                    n_state = S_TAKE0;
                end
            end
            S_SEARCH: begin
                if (w_match || !w_search_more) begin
                    n_state = S_FINISH;
                end
            end
            S_TAKE0: n_state = S_TAKE1;
            S_TAKE1: n_state = S_TAKE2;
            S_TAKE2: n_state = S_TAKE3;
            S_TAKE3: n_state = S_FINISH;
            S_RM1: begin
                n_state = iu_rd ? S_RM2 : S_FINISH;
            end
            S_RM2: n_state = S_FINISH;
            S_FINISH: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_count  = r_count;
        n_cur    = r_cur;
        n_nxt    = r_nxt;
        n_where  = r_where;
        n_steps  = r_steps;
        n_status = r_status;
        n_found  = r_found;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = AW'(r_cur);
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = AW'(r_slot);
        iu_we = 1'b0; iu_wa = '0; iu_wd = 1'b0; iu_ra = AW'(r_slot);
        el_we = 1'b0; el_wa = '0; el_ra = AW'(r_cur);
        case (r_state)
            // build free list chain and clear in-use bits
            S_CLEAR: begin
                nx_we = 1'b1;
                nx_wa = AW'(r_cur);
                nx_wd = r_cur + LW'(1);
                iu_we = 1'b1;
                iu_wa = AW'(r_cur);
                n_cur = (r_cur == LW'(CAPACITY - 1)) ? '0 : r_cur + LW'(1);
            end
            // check the request and start the walk or the reads
            S_DECODE: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                n_where  = '0;
                n_steps  = '0;
                case (r_kind)
                    KIND_INSERT: begin
                        if (w_pos_bad) begin
                            n_status = ST_BAD_POS;
                        end else if (!w_free_ok) begin
                            n_status = ST_FULL;
                        end else if (r_pos == '0) begin
                            n_cur = NULL_LINK;
                        end else begin
                            n_cur   = r_head;
                            n_steps = XW'(1);
                            nx_ra   = AW'(r_head);
                        end
                    end
                    KIND_APPEND: begin
                        if (!w_free_ok) begin
                            n_status = ST_FULL;
                        end
                        n_cur = r_tail;
                    end
                    KIND_SEARCH: begin
                        n_status = ST_NOT_FOUND;
                        n_cur    = r_head;
                        nx_ra    = AW'(r_head);
                        el_ra    = AW'(r_head);
                    end
                    default: begin
                        if (!w_slot_ok) begin
                            n_status = ST_NOT_IN_USE;
                        end
                        nx_ra = AW'(r_slot);
                    end
                endcase
            end
            // follow one link per cycle toward the insert point
            S_WALK: begin
                n_cur   = nx_rd;
                n_steps = w_step1;
                nx_ra   = AW'(nx_rd);
            end
            // compare one stored element per cycle
            S_SEARCH: begin
                if (w_match) begin
                    n_status = ST_OK;
                    n_found  = 1'b1;
                    n_where  = r_cur;
                end else begin
                    n_cur   = nx_rd;
                    n_steps = w_step1;
                    nx_ra   = AW'(nx_rd);
                    el_ra   = AW'(nx_rd);
                end
            end
            // take the free head slot
            S_TAKE0: begin
                nx_ra   = AW'(r_free);
                el_we   = 1'b1;
                el_wa   = AW'(r_free);
                iu_we   = 1'b1;
                iu_wa   = AW'(r_free);
                iu_wd   = 1'b1;
                n_where = r_free;
            end
            // advance free list, fetch successor of the insert point
            S_TAKE1: begin
                n_free = nx_rd;
                nx_ra  = AW'(r_cur);
            end
            // link the new node forward and backward
            S_TAKE2: begin
                n_nxt = w_take_nxt;
                nx_we = 1'b1;
                nx_wa = AW'(r_where);
                nx_wd = w_take_nxt;
                pv_we = 1'b1;
                pv_wa = AW'(r_where);
                pv_wd = r_cur;
                if (!w_cur_ok) begin
                    n_head = r_where;
                end
                if (!(w_take_nxt < NULL_LINK)) begin
                    n_tail = r_where;
                end
            end
            // patch the neighbors
            S_TAKE3: begin
                nx_we   = w_cur_ok;
                nx_wa   = AW'(r_cur);
                nx_wd   = r_where;
                pv_we   = w_nxt_ok;
                pv_wa   = AW'(r_nxt);
                pv_wd   = r_where;
                n_count = r_count + LW'(1);
            end
            // unlink the slot and push it on the free list
            S_RM1: begin
                if (!iu_rd) begin
                    n_status = ST_NOT_IN_USE;
                end else begin
                    n_cur  = pv_rd;
                    n_nxt  = nx_rd;
                    iu_we  = 1'b1;
                    iu_wa  = AW'(r_slot);
                    nx_we  = 1'b1;
                    nx_wa  = AW'(r_slot);
                    nx_wd  = r_free;
                    n_free = w_slot_l;
                    if (!w_pv_ok) begin
                        n_head = nx_rd;
                    end
                    if (!w_nx_ok) begin
                        n_tail = pv_rd;
                    end
                end
            end
            S_RM2: begin
                nx_we   = w_cur_ok;
                nx_wa   = AW'(r_cur);
                nx_wd   = r_nxt;
                pv_we   = w_nxt_ok;
                pv_wa   = AW'(r_nxt);
                pv_wd   = r_cur;
                n_where = w_slot_l;
                if (r_count != '0) begin
                    n_count = r_count - LW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // response valid: cleared on transfer, set when a result is loaded
    always_comb begin
        n_ov = r_ov;
        if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
        if (w_load_out) begin
            n_ov = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_head  <= NULL_LINK;
            r_tail  <= NULL_LINK;
            r_free  <= '0;
            r_count <= '0;
            r_cur   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_ov    <= n_ov;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_nxt    <= n_nxt;
        r_where  <= n_where;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_found  <= n_found;
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_elem <= EW'($unsigned(i_req.element));
            r_pos  <= i_req.position;
            r_slot <= i_req.slot;
        end
        if (w_load_out) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_slot   <= SLOT_W'(r_where);
            r_o_count  <= COUNT_W'(r_count);
        end
    end

    // channel outputs
    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.found      = r_o_found;
    assign o_rsp.slot_index = r_o_slot;
    assign o_rsp.count      = r_o_count;

endmodule
